// ----- src/json_token_writer_core_defines.svh -----
// json_token_writer_core_defines.svh: assertion macros for the json token writer checks
// expects signals named clk and rst in the scope where a macro is used
`ifndef JSON_TOKEN_WRITER_CORE_DEFINES_SVH
`define JSON_TOKEN_WRITER_CORE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define JTW_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define JTW_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/jtw_pkg.sv -----
// jtw_pkg: shared constants, types and helper functions of the json token writer
// no dependencies; used by every other file but jtw_ram and the defines header
package jtw_pkg;

  // nesting stack geometry
  localparam int STACK_DEPTH = 64;
  localparam int LVL_W       = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int ST_W        = 3;

  // container states held in the stack
  localparam logic [ST_W-1:0] ST_ARR      = 3'd0;
  localparam logic [ST_W-1:0] ST_ARR_NEXT = 3'd1;
  localparam logic [ST_W-1:0] ST_OBJ_KEY  = 3'd2;
  localparam logic [ST_W-1:0] ST_OBJ_VAL  = 3'd3;
  localparam logic [ST_W-1:0] ST_OBJ_NEXT = 3'd4;

  // writer commands
  localparam int CMD_W = 4;
  localparam logic [CMD_W-1:0] CMD_OPEN_OBJ  = 4'd0;
  localparam logic [CMD_W-1:0] CMD_CLOSE_OBJ = 4'd1;
  localparam logic [CMD_W-1:0] CMD_OPEN_ARR  = 4'd2;
  localparam logic [CMD_W-1:0] CMD_CLOSE_ARR = 4'd3;
  localparam logic [CMD_W-1:0] CMD_TRUE      = 4'd4;
  localparam logic [CMD_W-1:0] CMD_FALSE     = 4'd5;
  localparam logic [CMD_W-1:0] CMD_NULL      = 4'd6;
  localparam logic [CMD_W-1:0] CMD_STR_OPEN  = 4'd7;
  localparam logic [CMD_W-1:0] CMD_STR_CHAR  = 4'd8;
  localparam logic [CMD_W-1:0] CMD_STR_CLOSE = 4'd9;
  localparam logic [CMD_W-1:0] CMD_NUMBER    = 4'd10;

  // result status
  localparam int STAT_W = 2;
  localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_SYNTAX   = 2'd1;
  localparam logic [STAT_W-1:0] STAT_OVERFLOW = 2'd2;

  // decimal conversion
  localparam int NUM_W      = 64;
  localparam int BCD_DIGITS = 20;
  localparam int BCD_W      = 4 * BCD_DIGITS;
  localparam int STEP_W     = $clog2(NUM_W + 1);
  localparam int NDIG_W     = $clog2(BCD_DIGITS + 1);

  typedef struct packed {
    logic       neg;
    logic       digit_valid;
    logic [3:0] digit;
    logic       digit_last;
  } dec_stat_t;

  typedef struct packed {
    logic       hit;
    logic [7:0] code;
  } esc_t;

  // second byte of a two-byte escape
  function automatic esc_t esc_map(input logic [7:0] c);
    esc_t e;
    e.hit  = 1'b1;
    e.code = c;
    case (c)
      8'h0D:   e.code = "r";
      8'h0A:   e.code = "n";
      8'h09:   e.code = "t";
      8'h0B:   e.code = "v";
      8'h08:   e.code = "b";
      8'h5C:   e.code = 8'h5C;
      8'h22:   e.code = 8'h22;
      default: e.hit  = 1'b0;
    endcase
    return e;
  endfunction

  // state once a value has been completed
  function automatic logic [ST_W-1:0] adv_state(input logic [ST_W-1:0] s);
    logic [ST_W-1:0] n;
    n = s;
    case (s)
      ST_ARR:     n = ST_ARR_NEXT;
      ST_OBJ_KEY: n = ST_OBJ_VAL;
      ST_OBJ_VAL: n = ST_OBJ_NEXT;
      default:    n = s;
    endcase
    return n;
  endfunction

  // state once the separator before a value has gone out
  function automatic logic [ST_W-1:0] sep_state(input logic [ST_W-1:0] s);
    logic [ST_W-1:0] n;
    n = s;
    case (s)
      ST_ARR_NEXT: n = ST_ARR;
      ST_OBJ_NEXT: n = ST_OBJ_KEY;
      default:     n = s;
    endcase
    return n;
  endfunction

endpackage

// ----- src/jtw_in_if.sv -----
// jtw_in_if: command channel of the json token writer
// depends on jtw_pkg for field widths
interface jtw_in_if;
  logic                            valid;
  logic                            ready;
  logic [jtw_pkg::CMD_W-1:0]       command;
  logic [7:0]                      char_byte;
  logic signed [jtw_pkg::NUM_W-1:0] number_value;

  modport source (output valid, command, char_byte, number_value, input ready);
  modport sink (input valid, command, char_byte, number_value, output ready);
endinterface

// ----- src/jtw_out_if.sv -----
// jtw_out_if: text byte channel of the json token writer
// depends on jtw_pkg for field widths
interface jtw_out_if;
  logic                       valid;
  logic                       ready;
  logic [7:0]                 out_byte;
  logic [jtw_pkg::STAT_W-1:0] status;
  logic                       last;

  modport source (output valid, out_byte, status, last, input ready);
  modport sink (input valid, out_byte, status, last, output ready);
endinterface

// ----- src/jtw_ram.sv -----
// jtw_ram: generic single-write, single-read synchronous ram with registered read
// no dependencies
module jtw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/jtw_dec.sv -----
// jtw_dec: iterative binary to decimal converter, one bit per cycle (shift and add three)
// depends on jtw_pkg; hands out digits most significant first, leading zeros dropped
module jtw_dec (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [jtw_pkg::NUM_W-1:0] value,
  input  logic                      take,
  output jtw_pkg::dec_stat_t        stat
);

  localparam logic [1:0] P_IDLE  = 2'd0;
  localparam logic [1:0] P_CONV  = 2'd1;
  localparam logic [1:0] P_STRIP = 2'd2;
  localparam logic [1:0] P_OUT   = 2'd3;

  logic [1:0]                        phase;
  logic [jtw_pkg::NUM_W-1:0]         bin;
  logic [jtw_pkg::BCD_W-1:0]         bcd;
  logic [jtw_pkg::STEP_W-1:0]        steps;
  logic [jtw_pkg::NDIG_W-1:0]        ndig;
  logic                              neg;
  logic [jtw_pkg::NUM_W-1:0]         mag;
  logic [jtw_pkg::BCD_W-1:0]         adj;
  logic [3:0]                        top_dig;

  assign mag     = value[jtw_pkg::NUM_W-1] ? (~value + 1'b1) : value;
  assign top_dig = bcd[jtw_pkg::BCD_W-1 -: 4];

  // add three to every digit of five or more before the shift
  always_comb begin
    for (int i = 0; i < jtw_pkg::BCD_DIGITS; i++) begin
      adj[4*i +: 4] = (bcd[4*i +: 4] >= 4'd5) ? bcd[4*i +: 4] + 4'd3 : bcd[4*i +: 4];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= P_IDLE;
    end else if (start) begin
      phase <= P_CONV;
      bin   <= mag;
      bcd   <= '0;
      neg   <= value[jtw_pkg::NUM_W-1];
      steps <= jtw_pkg::STEP_W'(jtw_pkg::NUM_W);
    end else begin
      case (phase)
        P_CONV: begin
          bcd   <= {adj[jtw_pkg::BCD_W-2:0], bin[jtw_pkg::NUM_W-1]};
          bin   <= {bin[jtw_pkg::NUM_W-2:0], 1'b0};
          steps <= steps - 1'b1;
          if (steps == jtw_pkg::STEP_W'(1)) begin
            phase <= P_STRIP;
            ndig  <= jtw_pkg::NDIG_W'(jtw_pkg::BCD_DIGITS);
          end
        end
        P_STRIP: begin
          if (ndig > jtw_pkg::NDIG_W'(1) && top_dig == 4'd0) begin
            bcd  <= {bcd[jtw_pkg::BCD_W-5:0], 4'h0};
            ndig <= ndig - 1'b1;
          end else begin
            phase <= P_OUT;
          end
        end
        P_OUT: begin
          if (take) begin
            bcd  <= {bcd[jtw_pkg::BCD_W-5:0], 4'h0};
            ndig <= ndig - 1'b1;
            if (ndig == jtw_pkg::NDIG_W'(1)) begin
              phase <= P_IDLE;
            end
          end
        end
        default: phase <= P_IDLE;
      endcase
    end
  end

  assign stat.neg         = neg;
  assign stat.digit_valid = (phase == P_OUT);
  assign stat.digit       = top_dig;
  assign stat.digit_last  = (ndig == jtw_pkg::NDIG_W'(1));

endmodule

// ----- src/json_token_writer_core.sv -----
// json_token_writer_core: streaming json text writer, top level
// depends on jtw_pkg, jtw_in_if, jtw_out_if, jtw_ram and jtw_dec
// usage
//   token: one word per writer command (command, char_byte, number_value).
//   text:  one word per emitted json byte (out_byte, status, last); last marks
//          the final word caused by a command. an error gives a single word
//          with out_byte zero, a nonzero status and last set.
// timing
//   a command is looked up in the nesting stack ram in the cycle after it is
//   taken; an opening bracket then passes S_PUSH and a close that returns
//   to a parent passes S_FIX before S_EMIT hands its bytes to the output
//   register. bytes then leave at one per cycle while text.ready does not
//   stall them. the next command is taken on the edge that loads the last
//   byte. a number runs bit by bit through the shift-and-add converter,
//   which then drops leading zeros (up to 19) before its digits follow.
// reset
//   clears sequencer, nesting level, string flag, byte count and out_valid;
//   the stack ram is not cleared, as only entries below the level are used.
// stall
//   a byte waits in the output register while text.ready is low; the
//   sequencer holds and no new command is taken until the last byte loads.
module json_token_writer_core (
  input  logic        clk,
  input  logic        rst,
  jtw_in_if.sink      token,
  jtw_out_if.source   text
);

  // sequencer codes
  localparam logic [2:0] S_IDLE = 3'd0; // waiting for a command
  localparam logic [2:0] S_LOOK = 3'd1; // stack top read back, decide
  localparam logic [2:0] S_PUSH = 3'd2; // write the new container entry
  localparam logic [2:0] S_FIX  = 3'd3; // advance the parent after a close
  localparam logic [2:0] S_EMIT = 3'd4; // hand bytes to the output register

  logic [2:0]                        state;
  logic [jtw_pkg::LVL_W-1:0]         level;
  logic [jtw_pkg::LVL_W-1:0]         lvl_m1;
  logic [jtw_pkg::LVL_W-1:0]         lvl_m2;
  logic                              in_str;
  logic [jtw_pkg::CMD_W-1:0]         cmd;
  logic [7:0]                        chr;

  // byte queue of the current command, first byte at index zero
  logic [5:0][7:0]                   txt;
  logic [2:0]                        txt_cnt;
  logic                              num_tail;
  logic [jtw_pkg::STAT_W-1:0]        err_st;
  logic [jtw_pkg::ST_W-1:0]          push_st;

  // output register
  logic                              out_valid;
  logic [7:0]                        out_byte;
  logic [jtw_pkg::STAT_W-1:0]        out_status;
  logic                              out_last;

  // stack ram
  logic                              ram_we;
  logic [jtw_pkg::ADDR_W-1:0]        ram_waddr;
  logic [jtw_pkg::ST_W-1:0]          ram_wdata;
  logic [jtw_pkg::ADDR_W-1:0]        ram_raddr;
  logic [jtw_pkg::ST_W-1:0]          ram_rdata;

  // decimal converter
  logic                              dec_start;
  logic                              dec_take;
  jtw_pkg::dec_stat_t                dec_stat;

  // decision made in S_LOOK
  logic                              has_top;
  logic                              key_pos;
  logic                              sep_hit;
  logic [7:0]                        sep_byte;
  logic [jtw_pkg::ST_W-1:0]          sep_top;
  jtw_pkg::esc_t                     esc;
  logic [4:0][7:0]                   body;
  logic [2:0]                        body_len;
  logic                              use_sep;
  logic [jtw_pkg::STAT_W-1:0]        lk_err;
  logic                              lk_we;
  logic [jtw_pkg::ST_W-1:0]          lk_wdata;
  logic                              lk_push;
  logic [jtw_pkg::ST_W-1:0]          lk_push_st;
  logic                              lk_pop;
  logic                              lk_str_set;
  logic                              lk_str_clr;
  logic                              lk_num;
  logic [5:0][7:0]                   txt_load;
  logic [2:0]                        cnt_load;

  // emission
  logic                              byte_avail;
  logic [7:0]                        cur_byte;
  logic                              cur_last;
  logic                              out_free;
  logic                              fire;
  logic                              ready;
  logic                              acc;

  assign lvl_m1 = level - 1'b1;
  assign lvl_m2 = level - 2'd2;

  // ---------------------------------------------------------------------
  // decision on the stack top, valid in S_LOOK
  // ---------------------------------------------------------------------
  assign has_top  = (level != '0);
  assign key_pos  = has_top && (ram_rdata inside {jtw_pkg::ST_OBJ_KEY, jtw_pkg::ST_OBJ_NEXT});
  assign sep_hit  = has_top && (ram_rdata inside {jtw_pkg::ST_ARR_NEXT, jtw_pkg::ST_OBJ_NEXT,
                                                  jtw_pkg::ST_OBJ_VAL});
  assign sep_byte = (ram_rdata == jtw_pkg::ST_OBJ_VAL) ? ":" : ",";
  assign sep_top  = jtw_pkg::sep_state(ram_rdata);
  assign esc      = jtw_pkg::esc_map(chr);

  always_comb begin
    body       = '0;
    body_len   = 3'd0;
    use_sep    = 1'b0;
    lk_err     = jtw_pkg::STAT_OK;
    lk_we      = 1'b0;
    lk_wdata   = sep_top;
    lk_push    = 1'b0;
    lk_push_st = jtw_pkg::ST_ARR;
    lk_pop     = 1'b0;
    lk_str_set = 1'b0;
    lk_str_clr = 1'b0;
    lk_num     = 1'b0;
    if (in_str) begin
      case (cmd)
        jtw_pkg::CMD_STR_CHAR: begin
          if (esc.hit) begin
            body[0]  = 8'h5C;
            body[1]  = esc.code;
            body_len = 3'd2;
          end else begin
            body[0]  = chr;
            body_len = 3'd1;
          end
        end
        jtw_pkg::CMD_STR_CLOSE: begin
          body[0]    = 8'h22;
          body_len   = 3'd1;
          lk_str_clr = 1'b1;
          lk_we      = has_top;
          lk_wdata   = jtw_pkg::adv_state(ram_rdata);
        end
        default: lk_err = jtw_pkg::STAT_SYNTAX;
      endcase
    end else begin
      case (cmd)
        jtw_pkg::CMD_OPEN_OBJ, jtw_pkg::CMD_OPEN_ARR: begin
          if (key_pos) begin
            lk_err = jtw_pkg::STAT_SYNTAX;
          end else if (level == jtw_pkg::LVL_W'(jtw_pkg::STACK_DEPTH)) begin
            lk_err = jtw_pkg::STAT_OVERFLOW;
          end else begin
            use_sep    = sep_hit;
            body[0]    = (cmd == jtw_pkg::CMD_OPEN_OBJ) ? "{" : "[";
            body_len   = 3'd1;
            lk_we      = has_top;
            lk_wdata   = sep_top;
            lk_push    = 1'b1;
            lk_push_st = (cmd == jtw_pkg::CMD_OPEN_OBJ) ? jtw_pkg::ST_OBJ_KEY : jtw_pkg::ST_ARR;
          end
        end
        jtw_pkg::CMD_CLOSE_OBJ: begin
          if (!key_pos) begin
            lk_err = jtw_pkg::STAT_SYNTAX;
          end else begin
            body[0]  = "}";
            body_len = 3'd1;
            lk_pop   = 1'b1;
          end
        end
        jtw_pkg::CMD_CLOSE_ARR: begin
          if (!has_top || !(ram_rdata inside {jtw_pkg::ST_ARR, jtw_pkg::ST_ARR_NEXT})) begin
            lk_err = jtw_pkg::STAT_SYNTAX;
          end else begin
            body[0]  = "]";
            body_len = 3'd1;
            lk_pop   = 1'b1;
          end
        end
        jtw_pkg::CMD_TRUE, jtw_pkg::CMD_FALSE, jtw_pkg::CMD_NULL, jtw_pkg::CMD_NUMBER: begin
          if (key_pos) begin
            lk_err = jtw_pkg::STAT_SYNTAX;
          end else begin
            use_sep  = sep_hit;
            lk_we    = has_top;
            lk_wdata = jtw_pkg::adv_state(sep_top);
            if (cmd == jtw_pkg::CMD_TRUE) begin
              body[0]  = "t";
              body[1]  = "r";
              body[2]  = "u";
              body[3]  = "e";
              body_len = 3'd4;
            end else if (cmd == jtw_pkg::CMD_FALSE) begin
              body[0]  = "f";
              body[1]  = "a";
              body[2]  = "l";
              body[3]  = "s";
              body[4]  = "e";
              body_len = 3'd5;
            end else if (cmd == jtw_pkg::CMD_NULL) begin
              body[0]  = "n";
              body[1]  = "u";
              body[2]  = "l";
              body[3]  = "l";
              body_len = 3'd4;
            end else begin
              // sign goes out of the queue, digits follow from the converter
              body[0]  = "-";
              body_len = dec_stat.neg ? 3'd1 : 3'd0;
              lk_num   = 1'b1;
            end
          end
        end
        jtw_pkg::CMD_STR_OPEN: begin
          use_sep    = sep_hit;
          body[0]    = 8'h22;
          body_len   = 3'd1;
          lk_we      = has_top;
          lk_wdata   = sep_top;
          lk_str_set = 1'b1;
        end
        default: lk_err = jtw_pkg::STAT_SYNTAX;
      endcase
    end

    // separator in front of the body; an error is a single zero byte
    if (lk_err != jtw_pkg::STAT_OK) begin
      txt_load = '0;
      cnt_load = 3'd1;
    end else if (use_sep) begin
      txt_load = {body, sep_byte};
      cnt_load = body_len + 3'd1;
    end else begin
      txt_load = {8'h00, body};
      cnt_load = body_len;
    end
  end

  // ---------------------------------------------------------------------
  // stack ram access; a read that meets a write on one entry is never used,
  // as every write of a command is done before its bytes start to leave
  // ---------------------------------------------------------------------
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = lvl_m1[jtw_pkg::ADDR_W-1:0];
    ram_wdata = lk_wdata;
    case (state)
      S_LOOK: begin
        ram_we = lk_we;
      end
      S_PUSH: begin
        ram_we    = 1'b1;
        ram_waddr = level[jtw_pkg::ADDR_W-1:0];
        ram_wdata = push_st;
      end
      S_FIX: begin
        // level already lowered, read data holds the parent entry
        ram_we    = 1'b1;
        ram_wdata = jtw_pkg::adv_state(ram_rdata);
      end
      default: ram_we = 1'b0;
    endcase
  end

  // top entry on acceptance, the parent entry while a close is decided
  assign ram_raddr = (state == S_LOOK) ? lvl_m2[jtw_pkg::ADDR_W-1:0]
                                       : lvl_m1[jtw_pkg::ADDR_W-1:0];

  jtw_ram #(
    .WIDTH (jtw_pkg::ST_W),
    .DEPTH (jtw_pkg::STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------------
  // number conversion starts on acceptance and runs beside the lookup
  // ---------------------------------------------------------------------
  assign dec_start = acc && (token.command == jtw_pkg::CMD_NUMBER);
  assign dec_take  = fire && (txt_cnt == 3'd0);

  jtw_dec u_dec (
    .clk   (clk),
    .rst   (rst),
    .start (dec_start),
    .value (token.number_value),
    .take  (dec_take),
    .stat  (dec_stat)
  );

  // ---------------------------------------------------------------------
  // emission into the output register
  // ---------------------------------------------------------------------
  assign byte_avail = (txt_cnt != 3'd0) || (num_tail && dec_stat.digit_valid);
  assign cur_byte   = (txt_cnt != 3'd0) ? txt[0] : (8'h30 | {4'h0, dec_stat.digit});
  assign cur_last   = (txt_cnt != 3'd0) ? (txt_cnt == 3'd1 && !num_tail) : dec_stat.digit_last;
  assign out_free   = !out_valid || text.ready;
  assign fire       = (state == S_EMIT) && byte_avail && out_free;

  // next command is taken together with the last byte of the current one
  assign ready      = (state == S_IDLE) || (fire && cur_last);
  assign acc        = token.valid && ready;
  assign token.ready = ready;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      level     <= '0;
      in_str    <= 1'b0;
      txt_cnt   <= 3'd0;
      num_tail  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (fire) begin
        out_valid <= 1'b1;
      end else if (text.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (acc) begin
            state <= S_LOOK;
          end
        end
        S_LOOK: begin
          txt_cnt  <= cnt_load;
          num_tail <= lk_num;
          if (lk_str_set) begin
            in_str <= 1'b1;
          end else if (lk_str_clr) begin
            in_str <= 1'b0;
          end
          if (lk_pop) begin
            level <= lvl_m1;
          end
          if (lk_push) begin
            state <= S_PUSH;
          end else if (lk_pop && level > jtw_pkg::LVL_W'(1)) begin
            state <= S_FIX;
          end else begin
            state <= S_EMIT;
          end
        end
        S_PUSH: begin
          level <= level + 1'b1;
          state <= S_EMIT;
        end
        S_FIX: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (fire) begin
            if (txt_cnt != 3'd0) begin
              txt_cnt <= txt_cnt - 1'b1;
            end
            if (cur_last) begin
              state <= acc ? S_LOOK : S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (acc) begin
      cmd <= token.command;
      chr <= token.char_byte;
    end
    if (state == S_LOOK) begin
      txt     <= txt_load;
      err_st  <= lk_err;
      push_st <= lk_push_st;
    end else if (fire && txt_cnt != 3'd0) begin
      txt <= {8'h00, txt[5:1]};
    end
    if (fire) begin
      out_byte   <= cur_byte;
      out_status <= err_st;
      out_last   <= cur_last;
    end
  end

  assign text.valid    = out_valid;
  assign text.out_byte = out_byte;
  assign text.status   = out_status;
  assign text.last     = out_last;

endmodule

// ----- src/jtw_checker.sv -----
// jtw_checker: port-level assertions for json_token_writer_core, bound to the top level
// depends on jtw_pkg and json_token_writer_core_defines.svh
`include "json_token_writer_core_defines.svh"

module jtw_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       token_valid,
  input logic                       token_ready,
  input logic                       text_valid,
  input logic                       text_ready,
  input logic [7:0]                 text_out_byte,
  input logic [jtw_pkg::STAT_W-1:0] text_status,
  input logic                       text_last
);

  // a stalled word holds
  `JTW_ASSERT_NXT(a_text_hold, text_valid && !text_ready, text_valid && $stable(text_out_byte) && $stable(text_status) && $stable(text_last), "text word changed while stalled")

  // an error word is the only and last word of its command
  `JTW_ASSERT_IMP(a_err_word, text_valid && text_status != jtw_pkg::STAT_OK, text_last && text_out_byte == 8'h00, "error word not last or not zero")

  // every command is looked up in S_LOOK before the next one is taken
  `JTW_ASSERT_NXT(a_accept_gap, token_valid && token_ready, !token_ready, "commands taken on consecutive cycles")

endmodule

bind json_token_writer_core jtw_checker u_jtw_checker (
  .clk           (clk),
  .rst           (rst),
  .token_valid   (token.valid),
  .token_ready   (token.ready),
  .text_valid    (text.valid),
  .text_ready    (text.ready),
  .text_out_byte (text.out_byte),
  .text_status   (text.status),
  .text_last     (text.last)
);

// ----- tb/sv/json_token_writer_core_tb.sv -----
// json_token_writer_core_tb: self-checking bench for the streaming json text writer
// depends on jtw_pkg, jtw_in_if, jtw_out_if and json_token_writer_core
// a local nesting model predicts every text word; directed, overflow, stall and random tests
module json_token_writer_core_tb;
  import jtw_pkg::*;

  localparam int CLK_HALF       = 5;
  localparam int TIMEOUT_CYCLES = 3_000_000;
  localparam int HOLD_CYCLES    = 400;
  localparam int DRAIN_LIMIT    = 200_000;
  localparam int TAIL_CYCLES    = 120;
  localparam int IDLE_PCT       = 37;
  localparam int RANDOM_ITEMS   = 220;

  // command code that the writer does not define
  localparam logic [CMD_W-1:0] CMD_UNUSED_TOP = 4'd15;

  // bytes that the writer escapes
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_BSLSH = 8'h5C;
  localparam logic [7:0] CH_QUOTE = 8'h22;

  localparam logic [63:0] NUM_MIN = 64'h8000_0000_0000_0000;
  localparam logic [63:0] NUM_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] NUM_NEG1 = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic [7:0]        out_byte;
    logic [STAT_W-1:0] status;
    logic              last;
  } text_word_t;

  logic clk;
  logic rst;

  jtw_in_if  token ();
  jtw_out_if text ();

  json_token_writer_core u_top (
    .clk   (clk),
    .rst   (rst),
    .token (token),
    .text  (text)
  );

  // expected text words, oldest first
  text_word_t text_expect_q[$];
  int unsigned fail_count;

  // nesting model: container state per level, level count and string flag
  logic [ST_W-1:0] nest_ctx[STACK_DEPTH];
  int unsigned     nest_depth;
  bit              str_open;
  logic [7:0]      pend_bytes[$];

  // traffic shaping, set by the test tasks
  bit send_idle_en;
  bit recv_idle_en;
  bit hold_req;
  int unsigned hold_left;

  // ---------------------------------------------------------------------------
  // clock, timeout
  // ---------------------------------------------------------------------------
  initial clk = 1'b0;
  always #CLK_HALF clk = ~clk;

  initial begin
    #(TIMEOUT_CYCLES * 2 * CLK_HALF);
    $display("json_token_writer_core_tb failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // nesting model
  // ---------------------------------------------------------------------------
  // one predicted byte of the current command
  function automatic void put_byte(logic [7:0] b);
    pend_bytes.insert(pend_bytes.size(), b);
  endfunction

  // one expected text word at the tail of the queue
  function automatic void queue_word(logic [7:0] b, logic [STAT_W-1:0] st, logic lst);
    text_word_t w;
    w.out_byte = b;
    w.status   = st;
    w.last     = lst;
    text_expect_q.insert(text_expect_q.size(), w);
  endfunction

  function automatic void put_text(string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endfunction

  function automatic void set_top(logic [ST_W-1:0] s);
    nest_ctx[nest_depth - 1] = s;
  endfunction

  // comma or colon ahead of a value inside a container
  function automatic void emit_separator();
    if (nest_depth == 0) return;
    case (nest_ctx[nest_depth - 1])
      ST_ARR_NEXT: begin
        put_byte(",");
        set_top(ST_ARR);
      end
      ST_OBJ_NEXT: begin
        put_byte(",");
        set_top(ST_OBJ_KEY);
      end
      ST_OBJ_VAL: put_byte(":");
      default: ;
    endcase
  endfunction

  // a value has been completed at the current level
  function automatic void value_done();
    if (nest_depth == 0) return;
    case (nest_ctx[nest_depth - 1])
      ST_ARR:     set_top(ST_ARR_NEXT);
      ST_OBJ_KEY: set_top(ST_OBJ_VAL);
      ST_OBJ_VAL: set_top(ST_OBJ_NEXT);
      default: ;
    endcase
  endfunction

  // error: one word, zero byte, state untouched
  function automatic void expect_fault(logic [STAT_W-1:0] code);
    queue_word(8'h00, code, 1'b1);
  endfunction

  function automatic bit in_key_slot();
    if (nest_depth == 0) return 1'b0;
    return nest_ctx[nest_depth - 1] == ST_OBJ_KEY || nest_ctx[nest_depth - 1] == ST_OBJ_NEXT;
  endfunction

  // works out the text words of one accepted command and queues them
  function automatic void predict_text(logic [CMD_W-1:0] cmd, logic [7:0] ch,
                                       logic [63:0] num);
    bit         key_slot;
    logic [63:0] mag;
    logic [7:0] digit;
    logic [7:0] digs[$];

    pend_bytes.delete();
    key_slot = in_key_slot();
    if (str_open) begin
      if (cmd == CMD_STR_CHAR) begin
        case (ch)
          CH_CR:  put_text("\\r");
          CH_LF:  put_text("\\n");
          CH_TAB: put_text("\\t");
          CH_VT:  put_text("\\v");
          CH_BS:  put_text("\\b");
          CH_BSLSH, CH_QUOTE: begin
            put_byte(CH_BSLSH);
            put_byte(ch);
          end
          default: put_byte(ch);
        endcase
      end else if (cmd == CMD_STR_CLOSE) begin
        put_byte(CH_QUOTE);
        str_open = 1'b0;
        value_done();
      end else begin
        expect_fault(STAT_SYNTAX);
        return;
      end
    end else begin
      case (cmd)
        CMD_OPEN_OBJ, CMD_OPEN_ARR: begin
          if (key_slot) begin
            expect_fault(STAT_SYNTAX);
            return;
          end
          if (nest_depth >= STACK_DEPTH) begin
            expect_fault(STAT_OVERFLOW);
            return;
          end
          emit_separator();
          put_byte(cmd == CMD_OPEN_OBJ ? "{" : "[");
          nest_depth++;
          set_top(cmd == CMD_OPEN_OBJ ? ST_OBJ_KEY : ST_ARR);
        end
        CMD_CLOSE_OBJ, CMD_CLOSE_ARR: begin
          if (nest_depth == 0 || (cmd == CMD_CLOSE_OBJ) != key_slot ||
              (cmd == CMD_CLOSE_ARR && nest_ctx[nest_depth - 1] == ST_OBJ_VAL)) begin
            expect_fault(STAT_SYNTAX);
            return;
          end
          put_byte(cmd == CMD_CLOSE_OBJ ? "}" : "]");
          nest_depth--;
          value_done();
        end
        CMD_TRUE, CMD_FALSE, CMD_NULL, CMD_NUMBER: begin
          if (key_slot) begin
            expect_fault(STAT_SYNTAX);
            return;
          end
          emit_separator();
          case (cmd)
            CMD_TRUE:  put_text("true");
            CMD_FALSE: put_text("false");
            CMD_NULL:  put_text("null");
            default: begin
              // signed decimal, magnitude taken as unsigned so the minimum works
              mag = num;
              if (num[63]) begin
                put_byte("-");
                mag = ~num + 64'd1;
              end
              do begin
                digit = 8'(mag % 64'd10);
                digs.push_front(8'h30 + digit);
                mag = mag / 64'd10;
              end while (mag != 0);
              foreach (digs[i]) put_byte(digs[i]);
            end
          endcase
          value_done();
        end
        CMD_STR_OPEN: begin
          // a key is fine here, so no key slot check
          emit_separator();
          put_byte(CH_QUOTE);
          str_open = 1'b1;
        end
        default: begin
          expect_fault(STAT_SYNTAX);
          return;
        end
      endcase
    end
    foreach (pend_bytes[i])
      queue_word(pend_bytes[i], STAT_OK, i == pend_bytes.size() - 1);
  endfunction

  // ---------------------------------------------------------------------------
  // random choices
  // ---------------------------------------------------------------------------
  // mostly a command that fits the current nesting, now and then anything
  function automatic logic [CMD_W-1:0] pick_cmd();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 8) return CMD_W'($urandom_range(15));
    if (str_open) return (r < 78) ? CMD_STR_CHAR : CMD_STR_CLOSE;
    if (in_key_slot()) return (r < 75) ? CMD_STR_OPEN : CMD_CLOSE_OBJ;
    if (nest_depth != 0 && nest_ctx[nest_depth - 1] != ST_OBJ_VAL && r < 30)
      return CMD_CLOSE_ARR;
    case ($urandom_range(9))
      0:       return CMD_OPEN_OBJ;
      1:       return CMD_OPEN_ARR;
      2:       return CMD_TRUE;
      3:       return CMD_FALSE;
      4:       return CMD_NULL;
      5, 6:    return CMD_NUMBER;
      default: return CMD_STR_OPEN;
    endcase
  endfunction

  // escape bytes are favoured
  function automatic logic [7:0] pick_char();
    logic [7:0] esc_set[7];
    esc_set = '{CH_CR, CH_LF, CH_TAB, CH_VT, CH_BS, CH_BSLSH, CH_QUOTE};
    if ($urandom_range(99) < 30) return esc_set[$urandom_range(6)];
    return 8'($urandom);
  endfunction

  function automatic logic [63:0] pick_number();
    logic [63:0] v;
    logic [63:0] edge_set[5];
    edge_set = '{NUM_MIN, NUM_MAX, NUM_NEG1, 64'd0, 64'd10};
    case ($urandom_range(9))
      0: v = edge_set[$urandom_range(4)];
      1, 2, 3: begin
        v = 64'($urandom_range(999));
        if ($urandom_range(1)) v = -v;
      end
      default: v = {$urandom, $urandom};
    endcase
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // command side: entered and left at a falling edge
  // ---------------------------------------------------------------------------
  task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [7:0] ch,
                           input logic [63:0] num);
    // random gap, payload scrambled while nothing is offered
    while (send_idle_en && $urandom_range(99) < IDLE_PCT) begin
      token.valid        <= 1'b0;
      token.command      <= CMD_W'($urandom);
      token.char_byte    <= 8'($urandom);
      token.number_value <= {$urandom, $urandom};
      @(negedge clk);
    end
    token.valid        <= 1'b1;
    token.command      <= cmd;
    token.char_byte    <= ch;
    token.number_value <= num;
    do @(posedge clk); while (!token.ready);
    predict_text(cmd, ch, num);
    @(negedge clk);
  endtask

  // command whose payload is ignored, so junk goes with it
  task automatic send_op(input logic [CMD_W-1:0] cmd);
    send_word(cmd, pick_char(), pick_number());
  endtask

  // sender stays quiet until every expected word has come back
  task automatic wait_drained();
    token.valid <= 1'b0;
    @(negedge clk);
    while (text_expect_q.size() != 0) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // text side: ready pattern at the falling edge, hold counted here
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (rst) begin
      text.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      text.ready <= 1'b0;
    end else if (recv_idle_en) begin
      text.ready <= ($urandom_range(99) >= IDLE_PCT);
    end else begin
      text.ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // checker: every accepted word against the oldest expectation
  // ---------------------------------------------------------------------------
  function automatic void check_field(string what, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %h actual %h", $time, what, want, got);
    end
  endfunction

  always @(posedge clk) begin
    text_word_t want;
    if (!rst && text.valid === 1'b1 && text.ready === 1'b1) begin
      if (text_expect_q.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected text word, expected none actual byte %h status %0d last %b",
                 $time, text.out_byte, text.status, text.last);
      end else begin
        want = text_expect_q.pop_front();
        check_field("out_byte", want.out_byte, text.out_byte);
        check_field("status", 8'(want.status), 8'(text.status));
        check_field("last", 8'(want.last), 8'(text.last));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  // top-level values, extremes of the number, escapes, misplaced commands
  task automatic test_directed();
    send_op(CMD_TRUE);
    send_word(CMD_NUMBER, 8'h00, NUM_MIN);
    send_word(CMD_NUMBER, 8'hFF, NUM_MAX);
    send_op(CMD_CLOSE_OBJ);                // close with empty stack
    send_word(CMD_STR_CHAR, 8'h41, 64'd0); // character outside a string
    send_op(CMD_UNUSED_TOP);
    send_op(CMD_OPEN_OBJ);
    send_word(CMD_NUMBER, 8'h00, 64'd0);   // value where a key belongs
    send_op(CMD_STR_OPEN);
    send_word(CMD_STR_CHAR, CH_CR, 64'd0);
    send_word(CMD_STR_CHAR, CH_LF, 64'd0);
    send_word(CMD_STR_CHAR, CH_TAB, 64'd0);
    send_word(CMD_STR_CHAR, CH_VT, 64'd0);
    send_word(CMD_STR_CHAR, CH_BS, 64'd0);
    send_word(CMD_STR_CHAR, CH_BSLSH, 64'd0);
    send_word(CMD_STR_CHAR, CH_QUOTE, 64'd0);
    send_word(CMD_STR_CHAR, 8'hFF, 64'd0);
    send_op(CMD_CLOSE_ARR);                // any other command inside a string
    send_op(CMD_STR_CLOSE);
    send_op(CMD_CLOSE_OBJ);                // key waiting for its value
    send_op(CMD_OPEN_ARR);
    send_op(CMD_FALSE);
    send_word(CMD_NUMBER, 8'h00, NUM_NEG1);
    send_op(CMD_CLOSE_OBJ);                // mismatched close
    send_op(CMD_CLOSE_ARR);
    send_op(CMD_NULL);                     // non-string key after a comma
    send_op(CMD_STR_OPEN);
    send_op(CMD_STR_CLOSE);
    send_op(CMD_NULL);
    send_op(CMD_CLOSE_OBJ);
    send_op(CMD_STR_CLOSE);                // string close outside a string
  endtask

  // fill the stack to the brim, try one more object and one more array, then unwind
  task automatic test_overflow();
    repeat (STACK_DEPTH) send_op(CMD_OPEN_ARR);
    send_op(CMD_OPEN_OBJ);
    send_op(CMD_OPEN_ARR);
    repeat (STACK_DEPTH) send_op(CMD_CLOSE_ARR);
    wait_drained();
  endtask

  // receiver holds off while commands keep coming, so the block backs up
  task automatic test_backpressure();
    send_idle_en = 1'b0;
    hold_req     = 1'b1;
    repeat (40) send_word(pick_cmd(), pick_char(), pick_number());
    send_idle_en = 1'b1;
    wait_drained();
  endtask

  // random walk through the nesting; a middle stretch runs with no gaps at all
  task automatic test_random(input int unsigned n_items);
    for (int unsigned i = 0; i < n_items; i++) begin
      if (i == n_items / 3) begin
        send_idle_en = 1'b0;
        recv_idle_en = 1'b0;
      end else if (i == n_items / 2) begin
        send_idle_en = 1'b1;
        recv_idle_en = 1'b1;
      end
      send_word(pick_cmd(), pick_char(), pick_number());
    end
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned waited;
    rst                = 1'b1;
    token.valid        = 1'b0;
    token.command      = CMD_OPEN_OBJ;
    token.char_byte    = 8'h00;
    token.number_value = 64'd0;
    text.ready         = 1'b0;
    fail_count         = 0;
    nest_depth         = 0;
    str_open           = 1'b0;
    send_idle_en       = 1'b1;
    recv_idle_en       = 1'b1;
    hold_req           = 1'b0;
    hold_left          = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed();
    test_overflow();
    test_backpressure();
    test_random(RANDOM_ITEMS);

    token.valid <= 1'b0;
    waited = 0;
    while (text_expect_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (text_expect_q.size() != 0) begin
      fail_count++;
      $display("%0t: %0d text words never arrived, next expected byte %h status %0d",
               $time, text_expect_q.size(), text_expect_q[0].out_byte,
               text_expect_q[0].status);
    end
    // room for any stray word still in the number converter
    repeat (TAIL_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("json_token_writer_core_tb passed");
    end else begin
      $display("json_token_writer_core_tb failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+src
src/jtw_pkg.sv
src/jtw_in_if.sv
src/jtw_out_if.sv
src/jtw_ram.sv
src/jtw_dec.sv
src/json_token_writer_core.sv
src/jtw_checker.sv
tb/sv/json_token_writer_core_tb.sv
